>>> sv/sha_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0]  PadByte    = 8'h80;
  localparam logic [5:0]  LenPos     = 6'd56;

  typedef enum logic {
    REQ_ABSORB = 1'b0,
    REQ_FINISH = 1'b1
  } req_t;

  typedef struct packed {
    req_t       req;
    logic [7:0] data;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t init_h(input logic [2:0] i);
    case (i)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      3'd7: init_h = 32'h5be0cd19;
      default: init_h = 32'h0;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[i];
  endfunction

endpackage

>>> sv/sha_queue.sv
// front end: small fifo of classified request items
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sha_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output sha_pkg::item_t out_item
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::item_t     mem_r [Depth];
  logic [Aw-1:0]      wr_ptr_r, rd_ptr_r;
  logic [Aw:0]        count_r;
  logic               push, pop;

  assign in_ready  = (count_r != (Aw+1)'(Depth));
  assign out_valid = (count_r != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Aw'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Aw'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Aw+1)'(Depth))
    else $error("queue count over depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue push lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue pop lost");

endmodule

>>> sv/sha_core.sv
// back end: block buffer, padding sequencer and one-round-per-cycle compression
module sha_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  sha_pkg::item_t item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_digest_part0,
  output logic [63:0]    out_digest_part1,
  output logic [63:0]    out_digest_part2,
  output logic [63:0]    out_digest_part3
);

  sha_pkg::state_t  state_r, state_nxt;
  sha_pkg::word_t   buf_r [16];
  logic [5:0]       fill_r;
  logic [63:0]      bits_r;
  sha_pkg::word_t   h_r [8];
  sha_pkg::word_t   v_r [8];
  sha_pkg::word_t   w_r [16];
  logic [5:0]       rnd_r;
  logic             fin_r;
  logic             second_r;
  logic [5:0]       pad_r;
  logic             out_valid_r;

  sha_pkg::word_t   wt, s0, s1, ch, mj, t1, t2, sg0, sg1, wn;
  logic             take;
  logic             pad_wr;
  logic [7:0]       pad_byte;

  assign item_ready = (state_r == sha_pkg::ST_IDLE);
  assign take       = item_valid && item_ready;
  assign out_valid  = out_valid_r;

  // round datapath
  assign wt  = w_r[0];
  assign s1  = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1  = v_r[7] + s1 + ch + sha_pkg::round_k(rnd_r) + wt;
  assign s0  = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
  assign mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2  = s0 + mj;
  assign sg0 = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign sg1 = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign wn  = w_r[0] + sg0 + w_r[9] + sg1;

  // padding byte for position pad_r
  always_comb begin
    pad_wr   = (state_r == sha_pkg::ST_PAD);
    pad_byte = 8'h00;
    if (pad_r >= sha_pkg::LenPos && !(second_r == 1'b0 && fill_r >= sha_pkg::LenPos)) begin
      pad_byte = bits_r[8'(7 - int'(pad_r[2:0])) * 8 +: 8];
    end else if (pad_r == fill_r && !second_r) begin
      pad_byte = sha_pkg::PadByte;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha_pkg::ST_IDLE: begin
        if (take) begin
          if (item.req == sha_pkg::REQ_FINISH) begin
            state_nxt = sha_pkg::ST_PAD;
          end else if (fill_r == 6'd63) begin
            state_nxt = sha_pkg::ST_LOAD;
          end
        end
      end
      sha_pkg::ST_PAD:   if (pad_r == 6'd63) state_nxt = sha_pkg::ST_LOAD;
      sha_pkg::ST_LOAD:  state_nxt = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::ST_ADD;
      sha_pkg::ST_ADD: begin
        if (!fin_r) begin
          state_nxt = sha_pkg::ST_IDLE;
        end else if (!second_r && fill_r >= sha_pkg::LenPos) begin
          state_nxt = sha_pkg::ST_PAD;
        end else begin
          state_nxt = sha_pkg::ST_OUT;
        end
      end
      sha_pkg::ST_OUT:   if (!out_valid_r || out_ready) state_nxt = sha_pkg::ST_IDLE;
      default:           state_nxt = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // block buffer, sixteen big-endian words written one byte lane at a time
  always_ff @(posedge clk) begin
    if (take && item.req == sha_pkg::REQ_ABSORB) begin
      buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= item.data;
    end else if (pad_wr) begin
      buf_r[pad_r[5:2]][{~pad_r[1:0], 3'b000} +: 8] <= pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::ST_LOAD) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= buf_r[i];
      end
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (state_r == sha_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= wn;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  // digest leaves the chaining words only once the output register is free
  always_ff @(posedge clk) begin
    if (state_r == sha_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
      out_digest_part0 <= {h_r[0], h_r[1]};
      out_digest_part1 <= {h_r[2], h_r[3]};
      out_digest_part2 <= {h_r[4], h_r[5]};
      out_digest_part3 <= {h_r[6], h_r[7]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      bits_r      <= '0;
      rnd_r       <= '0;
      fin_r       <= 1'b0;
      second_r    <= 1'b0;
      pad_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sha_pkg::init_h(3'(i));
      end
    end else begin
      if (state_r == sha_pkg::ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        sha_pkg::ST_IDLE: begin
          if (take) begin
            if (item.req == sha_pkg::REQ_ABSORB) begin
              fill_r <= fill_r + 1'b1;
              bits_r <= bits_r + 64'd8;
              fin_r  <= 1'b0;
            end else begin
              fin_r    <= 1'b1;
              second_r <= 1'b0;
              pad_r    <= fill_r;
            end
          end
        end
        sha_pkg::ST_PAD: begin
          pad_r <= pad_r + 1'b1;
        end
        sha_pkg::ST_LOAD: begin
          rnd_r <= '0;
        end
        sha_pkg::ST_ROUND: begin
          rnd_r <= rnd_r + 1'b1;
        end
        sha_pkg::ST_ADD: begin
          if (!fin_r) begin
            for (int i = 0; i < 8; i++) begin
              h_r[i] <= h_r[i] + v_r[i];
            end
          end else if (!second_r && fill_r >= sha_pkg::LenPos) begin
            for (int i = 0; i < 8; i++) begin
              h_r[i] <= h_r[i] + v_r[i];
            end
            second_r <= 1'b1;
            pad_r    <= '0;
          end else begin
            for (int i = 0; i < 8; i++) begin
              h_r[i] <= h_r[i] + v_r[i];
            end
            fill_r   <= '0;
            bits_r   <= '0;
            fin_r    <= 1'b0;
            second_r <= 1'b0;
          end
        end
        sha_pkg::ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < 8; i++) begin
              h_r[i] <= sha_pkg::init_h(3'(i));
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha_pkg::ST_ROUND && rnd_r == 6'd63 |=> state_r == sha_pkg::ST_ADD)
    else $error("round count out of step");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("digest dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha_pkg::ST_OUT && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("digest not presented");
  assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> fin_r)
    else $error("second pad block without finish");

endmodule

>>> sv/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher: request queue and compression core
//
// channel  direction  signals
// in       input      in_valid, in_ready, in_req_type, in_data_byte
// out      output     out_valid, out_ready, out_digest_part0..3
//
// an absorb byte is taken while the core is idle; the 64th byte of a block
// starts load, 64 rounds and the chaining add, one round per cycle
// a finish is accepted, pads the rest of the block and compresses it, pads
// and compresses a second block when fewer than nine bytes are free, then
// presents the digest; a four-entry queue takes bytes while the core compresses
// rst_n is synchronous, active low, and restores the initial hash values
// a stalled digest holds in the output register; the core waits for it
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_part0,
  output logic [63:0] out_digest_part1,
  output logic [63:0] out_digest_part2,
  output logic [63:0] out_digest_part3
);

  sha_pkg::item_t in_item, q_item;
  logic           q_valid, q_ready;

  assign in_item.req  = sha_pkg::req_t'(in_req_type);
  assign in_item.data = in_data_byte;

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  sha_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (q_valid),
    .item_ready       (q_ready),
    .item             (q_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_digest_part0 (out_digest_part0),
    .out_digest_part1 (out_digest_part1),
    .out_digest_part2 (out_digest_part2),
    .out_digest_part3 (out_digest_part3)
  );

endmodule

>>> bench/sha256_stream_hasher_test.sv
// testbench for the sha-256 stream hasher: byte stream stimulus, scoreboard with its own sha-256
module sha256_stream_hasher_test;

  class digest_board;
    logic [31:0] chain [8];
    logic [7:0]  buffer [64];
    int unsigned fill;
    logic [63:0] msg_bits;
    logic [255:0] pending [$];
    int errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (buffer[i]) buffer[i] = 8'h00;
      fill = 0;
      msg_bits = 64'd0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1, k_tab [64];
      k_tab = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++)
        w[i] = {buffer[4*i], buffer[4*i+1], buffer[4*i+2], buffer[4*i+3]};
      for (int i = 16; i < 64; i++) begin
        s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
        s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
        w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      v = chain;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
             + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_tab[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
             + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    function void note_transfer(sha_pkg::req_t req, logic [7:0] data);
      int unsigned pos;
      if (req == sha_pkg::REQ_ABSORB) begin
        buffer[fill] = data;
        msg_bits += 64'd8;
        fill = (fill + 1) % 64;
        if (fill == 0) compress();
        return;
      end
      pos = fill;
      buffer[pos] = sha_pkg::PadByte;
      pos++;
      if (pos > sha_pkg::LenPos) begin
        while (pos < 64) buffer[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < sha_pkg::LenPos) buffer[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) buffer[56+i] = msg_bits[(7-i)*8 +: 8];
      compress();
      pending.push_back({chain[0], chain[1], chain[2], chain[3],
                         chain[4], chain[5], chain[6], chain[7]});
      restart();
    endfunction

    task check_digest(logic [63:0] p0, p1, p2, p3);
      logic [255:0] want;
      if (pending.size() == 0) begin
        report("digest with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (p0 !== want[255:192]) report("digest_part0 mismatch");
      if (p1 !== want[191:128]) report("digest_part1 mismatch");
      if (p2 !== want[127:64]) report("digest_part2 mismatch");
      if (p3 !== want[63:0]) report("digest_part3 mismatch");
    endtask

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_req_type;
  logic [7:0] in_data_byte;
  logic out_valid, out_ready;
  logic [63:0] out_digest_part0, out_digest_part1, out_digest_part2, out_digest_part3;

  digest_board board = new();
  bit long_hold;
  int idle_cycles;

  sha256_stream_hasher uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // send one item and wait until it is accepted
  task automatic send_item(sha_pkg::req_t req, logic [7:0] data);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_data_byte <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    in_data_byte <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_message(int len, int mode);
    int burst;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < len; i++) begin
      send_item(sha_pkg::REQ_ABSORB, mode == 1 ? 8'hff : mode == 2 ? 8'h00 : 8'($urandom));
      if (--burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 6));
      end
    end
    send_item(sha_pkg::REQ_FINISH, 8'($urandom));
    if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 4));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_transfer(sha_pkg::req_t'(in_req_type), in_data_byte);
    end
    if (rst_n && out_valid && out_ready)
      board.check_digest(out_digest_part0, out_digest_part1, out_digest_part2, out_digest_part3);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    phase = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      phase++;
      if ((phase / 200) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= (phase % 7 < 3) || ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("sha256_stream_hasher_test NOT OK");
      $finish;
    end
  end

  initial begin
    int sent;
    idle_cycles = 0;
    long_hold = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req_type <= sha_pkg::REQ_ABSORB;
    in_data_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty, one byte, extremes, pad boundaries at 55, 56, 63, 64
    send_message(0, 0);
    send_message(1, 1);
    send_message(1, 2);
    send_message(3, 0);
    drain();
    send_message(55, 0);
    send_message(56, 1);
    send_message(63, 2);
    send_message(64, 0);
    drain();
    // long receiver hold while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send_message($urandom_range(0, 10), 0);
    drain();
    sent = 0;
    while (sent < 1650) begin
      int len;
      case ($urandom_range(0, 5))
        0: len = $urandom_range(0, 3);
        1: len = $urandom_range(52, 68);
        2: len = $urandom_range(110, 140);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len, $urandom_range(0, 9) == 0 ? 1 : 0);
      sent += len + 1;
    end
    drain();
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("sha256_stream_hasher_test OK");
    end else begin
      $display("sha256_stream_hasher_test NOT OK");
    end
    $finish;
  end
endmodule
